// File: sv/scs_pkg.sv
// Package with shared constants and types for the spectral coefficient shrink block.
`default_nettype none
package scs_pkg;

  localparam int COEF_W  = 24;
  localparam int FRAC    = 16;
  localparam int NOISE_W = 48;
  localparam int MG_W    = 40;
  localparam int ACC_W   = 66;
  localparam int DMAG_W  = 31;
  localparam int M_W     = 33;
  localparam int PSD_W   = 63;
  localparam int CNT_W   = 6;

  localparam logic [0:0] REG_FILTER_MODE = 1'b0;
  localparam logic [0:0] REG_ZERO_MEAN   = 1'b1;

  typedef enum logic [1:0] {
    MODE_WIENER = 2'd0,
    MODE_SQRT   = 2'd1,
    MODE_HARD   = 2'd2,
    MODE_MULT   = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MG_DIV,
    S_MG_SET,
    S_ZM,
    S_MR_MUL,
    S_MR_RND,
    S_MR_SGN,
    S_D_SUB,
    S_PSD_INIT,
    S_PSD_MUL,
    S_PSD_ADD,
    S_GAIN,
    S_WCMP,
    S_WDIV,
    S_SQ_INIT,
    S_SQ,
    S_SC_INIT,
    S_SC_MUL,
    S_SC_RND,
    S_SC_SGN,
    S_OUT_ADD
  } state_t;

endpackage
`default_nettype wire

// File: sv/spectral_coef_shrink.sv
// Spectral coefficient shrinkage with Wiener, square-root, hard-threshold and gain modes.
//
// One item on the input channel (in_valid/in_ready) carries a complex coefficient,
// its noise level, the matching reference coefficient and a block start flag.
// Each item gives one result item on the output channel (out_valid/out_ready).
// Most arithmetic runs on one shared 66-bit adder under a sequencer: the mean gain
// division takes 40 steps, each multiply one step per multiplier bit, the Wiener
// gain 17 steps and the square root 17 steps. in_ready is high only while the
// sequencer is idle. A finished result sits in the output register, so the next
// item is taken while it waits; a stalled receiver holds the sequencer at its
// last step. Configuration is written through cfg_we, cfg_index and cfg_wdata;
// the user must write it only while idle, as the block does not enforce this.
// Synchronous reset clears the sequencer, the output valid flag and the mean
// gain, and sets filter_mode to Wiener and zero_mean_enable to on.
`default_nettype none
module spectral_coef_shrink (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_index,
  input  wire logic [1:0]                   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [scs_pkg::COEF_W-1:0] in_coef_real,
  input  wire logic signed [scs_pkg::COEF_W-1:0] in_coef_imag,
  input  wire logic [scs_pkg::NOISE_W-1:0]  in_noise_level,
  input  wire logic signed [scs_pkg::COEF_W-1:0] in_ref_real,
  input  wire logic signed [scs_pkg::COEF_W-1:0] in_ref_imag,
  input  wire logic                         in_block_first,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [scs_pkg::COEF_W-1:0] out_real,
  output logic signed [scs_pkg::COEF_W-1:0] out_imag
);
  import scs_pkg::*;

  localparam logic signed [ACC_W-1:0] D_HI = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] D_LO = -66'sd2147483647;
  localparam logic signed [ACC_W-1:0] O_HI = 66'sd8388607;
  localparam logic signed [ACC_W-1:0] O_LO = -66'sd8388608;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC - 1);
  localparam logic [ACC_W-FRAC-1:0] M_LIM  = (ACC_W-FRAC)'(64'h7fff_ffff);
  localparam logic [ACC_W-FRAC-1:0] SC_LIM = (ACC_W-FRAC)'(64'h2_0000_0000);

  state_t state_r, state_nxt;
  mode_t  mode_r;
  logic   zme_r;
  logic   part_r, part_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic signed [COEF_W-1:0] c_re_r, c_im_r, r_re_r, r_im_r;
  logic signed [COEF_W-1:0] c_re_nxt, c_im_nxt, r_re_nxt, r_im_nxt;
  logic [NOISE_W-1:0] sigma_r, sigma_nxt;
  logic signed [MG_W-1:0] mg_r, mg_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt, opa_r, opa_nxt;
  logic [63:0] shr_r, shr_nxt;
  logic signed [M_W-1:0] mr_r, mi_r, dr_r, di_r, mr_nxt, mi_nxt, dr_nxt, di_nxt;
  logic [PSD_W-1:0] psd_r, psd_nxt;
  logic [NOISE_W-1:0] gain_r, gain_nxt;
  logic sat_r, sat_nxt;
  logic signed [COEF_W-1:0] res_re_r, res_re_nxt;
  logic signed [COEF_W-1:0] out_re_r, out_im_r, out_re_nxt, out_im_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [ACC_W-1:0] add_a, add_b, add_res;
  logic add_sub, add_neg;

  logic signed [COEF_W-1:0] cur_c, cur_r;
  logic signed [M_W-1:0] cur_m, cur_d, neg_d;
  logic [COEF_W-1:0] mag_cur_r, in_mag_cr, in_mag_rr;
  logic [MG_W-1:0] mag_mg;
  logic [DMAG_W-1:0] mag_cur_d;
  logic [ACC_W-FRAC-1:0] rnd_q;
  logic [DMAG_W-1:0] m_mag;
  logic [M_W:0] sc_mag;
  logic m_neg;
  logic [33:0] sq_t, sq_up;
  logic signed [ACC_W-1:0] sres;
  logic signed [COEF_W-1:0] o_sat;
  logic signed [M_W-1:0] d_sat;
  logic can_load;
  logic q_bit;

  assign cur_c     = part_r ? c_im_r : c_re_r;
  assign cur_r     = part_r ? r_im_r : r_re_r;
  assign cur_m     = part_r ? mi_r : mr_r;
  assign cur_d     = part_r ? di_r : dr_r;
  assign neg_d     = -cur_d;
  assign mag_cur_d = cur_d[M_W-1] ? neg_d[DMAG_W-1:0] : cur_d[DMAG_W-1:0];
  assign mag_cur_r = cur_r[COEF_W-1] ? COEF_W'(-cur_r) : COEF_W'(cur_r);
  assign in_mag_cr = in_coef_real[COEF_W-1] ? COEF_W'(-in_coef_real) : COEF_W'(in_coef_real);
  assign in_mag_rr = in_ref_real[COEF_W-1] ? COEF_W'(-in_ref_real) : COEF_W'(in_ref_real);
  assign mag_mg    = mg_r[MG_W-1] ? MG_W'(-mg_r) : MG_W'(mg_r);
  assign rnd_q     = acc_r[ACC_W-1:FRAC];
  assign m_mag     = (rnd_q > M_LIM) ? M_LIM[DMAG_W-1:0] : rnd_q[DMAG_W-1:0];
  assign sc_mag    = (sat_r || rnd_q > SC_LIM) ? SC_LIM[M_W:0] : rnd_q[M_W:0];
  assign m_neg     = mg_r[MG_W-1] ^ cur_r[COEF_W-1];
  assign sq_t      = opa_r[33:0] + shr_r[33:0];
  assign sq_up     = {1'b0, opa_r[33:1]} + shr_r[33:0];
  assign sres      = $signed(add_res);
  assign d_sat     = (sres > D_HI) ? M_W'(D_HI) : ((sres < D_LO) ? M_W'(D_LO) : M_W'(sres));
  assign o_sat     = (sres > O_HI) ? COEF_W'(O_HI) : ((sres < O_LO) ? COEF_W'(O_LO) : COEF_W'(sres));
  assign add_neg   = add_res[ACC_W-1];
  assign q_bit     = !add_neg;
  assign can_load  = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_real  = out_re_r;
  assign out_imag  = out_im_r;

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_MG_DIV: begin
        add_a   = {acc_r[ACC_W-2:0], shr_r[MG_W-1]};
        add_b   = opa_r;
        add_sub = 1'b1;
      end
      S_MG_SET: begin
        add_b   = {{(ACC_W-MG_W){1'b0}}, shr_r[MG_W-1:0]};
        add_sub = 1'b1;
      end
      S_MR_MUL: begin
        add_a = {acc_r[ACC_W-2:0], 1'b0};
        add_b = shr_r[COEF_W-1] ? opa_r : '0;
      end
      S_MR_RND, S_SC_RND: begin
        add_a = acc_r;
        add_b = RND_HALF;
      end
      S_MR_SGN: begin
        add_a   = m_neg ? '0 : {{(ACC_W-DMAG_W){1'b0}}, m_mag};
        add_b   = m_neg ? {{(ACC_W-DMAG_W){1'b0}}, m_mag} : '0;
        add_sub = m_neg;
      end
      S_D_SUB: begin
        add_a   = {{(ACC_W-COEF_W){cur_c[COEF_W-1]}}, cur_c};
        add_b   = {{(ACC_W-M_W){cur_m[M_W-1]}}, cur_m};
        add_sub = 1'b1;
      end
      S_PSD_MUL, S_SC_MUL: begin
        add_a = {acc_r[ACC_W-2:0], 1'b0};
        add_b = shr_r[DMAG_W-1] ? opa_r : '0;
      end
      S_PSD_ADD: begin
        add_a = {{(ACC_W-PSD_W){1'b0}}, psd_r};
        add_b = acc_r;
      end
      S_GAIN: begin
        add_a   = {{(ACC_W-PSD_W){1'b0}}, psd_r};
        add_b   = {{(ACC_W-NOISE_W){1'b0}}, sigma_r};
        add_sub = 1'b1;
      end
      S_WCMP: begin
        add_a   = acc_r;
        add_b   = {{(ACC_W-PSD_W){1'b0}}, psd_r};
        add_sub = 1'b1;
      end
      S_WDIV: begin
        add_a   = {acc_r[ACC_W-2:0], 1'b0};
        add_b   = {{(ACC_W-PSD_W){1'b0}}, psd_r};
        add_sub = 1'b1;
      end
      S_SQ: begin
        add_a   = acc_r;
        add_b   = {{(ACC_W-34){1'b0}}, sq_t};
        add_sub = 1'b1;
      end
      S_SC_SGN: begin
        add_a   = cur_d[M_W-1] ? '0 : {{(ACC_W-M_W-1){1'b0}}, sc_mag};
        add_b   = cur_d[M_W-1] ? {{(ACC_W-M_W-1){1'b0}}, sc_mag} : '0;
        add_sub = cur_d[M_W-1];
      end
      S_OUT_ADD: begin
        add_a = acc_r;
        add_b = {{(ACC_W-M_W){cur_m[M_W-1]}}, cur_m};
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_res = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, add_sub};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_block_first && in_ref_real != '0) ? S_MG_DIV : S_ZM;
        end
      end
      S_MG_DIV:   state_nxt = (cnt_r == CNT_W'(MG_W - 1)) ? S_MG_SET : S_MG_DIV;
      S_MG_SET:   state_nxt = S_ZM;
      S_ZM:       state_nxt = zme_r ? S_MR_MUL : S_PSD_INIT;
      S_MR_MUL:   state_nxt = (cnt_r == CNT_W'(COEF_W - 1)) ? S_MR_RND : S_MR_MUL;
      S_MR_RND:   state_nxt = S_MR_SGN;
      S_MR_SGN:   state_nxt = S_D_SUB;
      S_D_SUB:    state_nxt = part_r ? S_PSD_INIT : S_MR_MUL;
      S_PSD_INIT: state_nxt = S_PSD_MUL;
      S_PSD_MUL:  state_nxt = (cnt_r == CNT_W'(DMAG_W - 1)) ? S_PSD_ADD : S_PSD_MUL;
      S_PSD_ADD:  state_nxt = part_r ? S_GAIN : S_PSD_INIT;
      S_GAIN: begin
        if ((mode_r == MODE_WIENER || mode_r == MODE_SQRT) && !add_neg && add_res != '0) begin
          state_nxt = S_WCMP;
        end else begin
          state_nxt = S_SC_INIT;
        end
      end
      S_WCMP:     state_nxt = S_WDIV;
      S_WDIV: begin
        if (cnt_r == CNT_W'(FRAC - 1)) begin
          state_nxt = (mode_r == MODE_SQRT) ? S_SQ_INIT : S_SC_INIT;
        end
      end
      S_SQ_INIT:  state_nxt = S_SQ;
      S_SQ:       state_nxt = (cnt_r == CNT_W'(FRAC)) ? S_SC_INIT : S_SQ;
      S_SC_INIT:  state_nxt = S_SC_MUL;
      S_SC_MUL:   state_nxt = (cnt_r == CNT_W'(DMAG_W - 1)) ? S_SC_RND : S_SC_MUL;
      S_SC_RND:   state_nxt = S_SC_SGN;
      S_SC_SGN:   state_nxt = S_OUT_ADD;
      S_OUT_ADD: begin
        if (!part_r) begin
          state_nxt = S_SC_INIT;
        end else if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    part_nxt      = part_r;
    cnt_nxt       = cnt_r + CNT_W'(1);
    c_re_nxt      = c_re_r;
    c_im_nxt      = c_im_r;
    r_re_nxt      = r_re_r;
    r_im_nxt      = r_im_r;
    sigma_nxt     = sigma_r;
    mg_nxt        = mg_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    shr_nxt       = shr_r;
    mr_nxt        = mr_r;
    mi_nxt        = mi_r;
    dr_nxt        = dr_r;
    di_nxt        = di_r;
    psd_nxt       = psd_r;
    gain_nxt      = gain_r;
    sat_nxt       = sat_r;
    res_re_nxt    = res_re_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        cnt_nxt   = '0;
        part_nxt  = 1'b0;
        c_re_nxt  = in_coef_real;
        c_im_nxt  = in_coef_imag;
        r_re_nxt  = in_ref_real;
        r_im_nxt  = in_ref_imag;
        sigma_nxt = in_noise_level;
        acc_nxt   = '0;
        opa_nxt   = {{(ACC_W-COEF_W){1'b0}}, in_mag_rr};
        shr_nxt   = {{(64-MG_W){1'b0}}, in_mag_cr, {FRAC{1'b0}}};
        if (in_valid && in_block_first && in_ref_real == '0) begin
          mg_nxt = '0;
        end
      end
      S_MG_DIV: begin
        acc_nxt = q_bit ? add_res : add_a;
        shr_nxt = {shr_r[62:0], q_bit};
      end
      S_MG_SET: begin
        if (c_re_r[COEF_W-1] ^ r_re_r[COEF_W-1]) begin
          mg_nxt = $signed(add_res[MG_W-1:0]);
        end else if (shr_r[MG_W-1]) begin
          mg_nxt = {1'b0, {(MG_W-1){1'b1}}};
        end else begin
          mg_nxt = $signed(shr_r[MG_W-1:0]);
        end
      end
      S_ZM: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        opa_nxt = {{(ACC_W-MG_W){1'b0}}, mag_mg};
        shr_nxt = {{(64-COEF_W){1'b0}}, mag_cur_r};
        if (!zme_r) begin
          mr_nxt = '0;
          mi_nxt = '0;
          dr_nxt = M_W'(c_re_r);
          di_nxt = M_W'(c_im_r);
        end
      end
      S_MR_MUL: begin
        acc_nxt = add_res;
        shr_nxt = {shr_r[62:0], 1'b0};
      end
      S_MR_RND: begin
        acc_nxt = add_res;
      end
      S_MR_SGN: begin
        if (part_r) begin
          mi_nxt = $signed(add_res[M_W-1:0]);
        end else begin
          mr_nxt = $signed(add_res[M_W-1:0]);
        end
      end
      S_D_SUB: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        shr_nxt = {{(64-COEF_W){1'b0}}, r_im_r[COEF_W-1] ? COEF_W'(-r_im_r) : COEF_W'(r_im_r)};
        if (part_r) begin
          di_nxt   = d_sat;
          part_nxt = 1'b0;
        end else begin
          dr_nxt   = d_sat;
          part_nxt = 1'b1;
        end
      end
      S_PSD_INIT: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        opa_nxt = {{(ACC_W-DMAG_W){1'b0}}, mag_cur_d};
        shr_nxt = {{(64-DMAG_W){1'b0}}, mag_cur_d};
        if (!part_r) begin
          psd_nxt = '0;
        end
      end
      S_PSD_MUL: begin
        acc_nxt = add_res;
        shr_nxt = {shr_r[62:0], 1'b0};
      end
      S_PSD_ADD: begin
        psd_nxt  = add_res[PSD_W-1:0];
        part_nxt = !part_r;
      end
      S_GAIN: begin
        acc_nxt = add_res;
        case (mode_r)
          MODE_WIENER, MODE_SQRT: gain_nxt = '0;
          MODE_HARD: gain_nxt = add_neg ? '0 : NOISE_W'(1) << FRAC;
          default:   gain_nxt = sigma_r;
        endcase
      end
      S_WCMP: begin
        cnt_nxt = '0;
        if (q_bit) begin
          acc_nxt = add_res;
        end
        shr_nxt = {63'b0, q_bit};
      end
      S_WDIV: begin
        acc_nxt = q_bit ? add_res : add_a;
        shr_nxt = {shr_r[62:0], q_bit};
        if (cnt_r == CNT_W'(FRAC - 1)) begin
          gain_nxt = NOISE_W'({shr_r[FRAC-1:0], q_bit});
        end
      end
      S_SQ_INIT: begin
        cnt_nxt = '0;
        acc_nxt = {{(ACC_W-FRAC-FRAC-1){1'b0}}, gain_r[FRAC:0], {FRAC{1'b0}}};
        opa_nxt = '0;
        shr_nxt = 64'(1) << (2 * FRAC);
      end
      S_SQ: begin
        if (q_bit) begin
          acc_nxt = add_res;
          opa_nxt = {{(ACC_W-34){1'b0}}, sq_up};
        end else begin
          opa_nxt = {1'b0, opa_r[ACC_W-1:1]};
        end
        shr_nxt = {2'b0, shr_r[63:2]};
        if (cnt_r == CNT_W'(FRAC)) begin
          gain_nxt = q_bit ? NOISE_W'(sq_up) : NOISE_W'(opa_r[ACC_W-1:1]);
        end
      end
      S_SC_INIT: begin
        cnt_nxt = '0;
        acc_nxt = '0;
        sat_nxt = 1'b0;
        opa_nxt = {{(ACC_W-NOISE_W){1'b0}}, gain_r};
        shr_nxt = {{(64-DMAG_W){1'b0}}, mag_cur_d};
      end
      S_SC_MUL: begin
        shr_nxt = {shr_r[62:0], 1'b0};
        if (!sat_r) begin
          acc_nxt = add_res;
          sat_nxt = (add_res[ACC_W-1:50] != '0);
        end
      end
      S_SC_RND, S_SC_SGN: begin
        acc_nxt = add_res;
      end
      S_OUT_ADD: begin
        if (!part_r) begin
          res_re_nxt = o_sat;
          part_nxt   = 1'b1;
        end else if (can_load) begin
          out_re_nxt    = res_re_r;
          out_im_nxt    = o_sat;
          out_valid_nxt = 1'b1;
          part_nxt      = 1'b0;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_WIENER;
      zme_r       <= 1'b1;
      mg_r        <= '0;
      out_valid_r <= 1'b0;
      part_r      <= 1'b0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mg_r        <= mg_nxt;
      out_valid_r <= out_valid_nxt;
      part_r      <= part_nxt;
      cnt_r       <= cnt_nxt;
      sat_r       <= sat_nxt;
      if (cfg_we && cfg_index == REG_FILTER_MODE) begin
        mode_r <= mode_t'(cfg_wdata);
      end
      if (cfg_we && cfg_index == REG_ZERO_MEAN) begin
        zme_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    c_re_r   <= c_re_nxt;
    c_im_r   <= c_im_nxt;
    r_re_r   <= r_re_nxt;
    r_im_r   <= r_im_nxt;
    sigma_r  <= sigma_nxt;
    acc_r    <= acc_nxt;
    opa_r    <= opa_nxt;
    shr_r    <= shr_nxt;
    mr_r     <= mr_nxt;
    mi_r     <= mi_nxt;
    dr_r     <= dr_nxt;
    di_r     <= di_nxt;
    psd_r    <= psd_nxt;
    gain_r   <= gain_nxt;
    res_re_r <= res_re_nxt;
    out_re_r <= out_re_nxt;
    out_im_r <= out_im_nxt;
  end

`ifndef SYNTH
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> state_r == S_IDLE && !out_valid_r)
    else $error("sequencer not idle after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted item did not start the sequencer");

  a_load_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT_ADD && $past(part_r))
    else $error("result item loaded outside the final step");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SC_MUL && mode_r != MODE_MULT |-> gain_r <= (NOISE_W'(1) << FRAC))
    else $error("shrink gain above unity");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the spectral coefficient shrink block.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import scs_pkg::*;

  typedef struct {
    logic signed [COEF_W-1:0] coef_real;
    logic signed [COEF_W-1:0] coef_imag;
    logic [NOISE_W-1:0]       noise_level;
    logic signed [COEF_W-1:0] ref_real;
    logic signed [COEF_W-1:0] ref_imag;
    logic                     block_first;
  } coef_item_t;

  typedef struct {
    logic signed [COEF_W-1:0] re;
    logic signed [COEF_W-1:0] im;
  } shrunk_t;

  localparam longint unsigned P62      = 64'd1 << 62;
  localparam longint unsigned D_LIM    = 64'd2147483647;
  localparam longint unsigned SCL_LIM  = 64'd1 << 33;
  localparam longint          MG_MAX   = 64'sd549755813887;
  localparam longint          MG_MIN   = -64'sd549755813888;
  localparam longint          CYC_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COEF_W-1:0] in_coef_real = '0;
  logic signed [COEF_W-1:0] in_coef_imag = '0;
  logic [NOISE_W-1:0] in_noise_level = '0;
  logic signed [COEF_W-1:0] in_ref_real = '0;
  logic signed [COEF_W-1:0] in_ref_imag = '0;
  logic in_block_first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEF_W-1:0] out_real;
  logic signed [COEF_W-1:0] out_imag;

  coef_item_t pending_items[$];
  shrunk_t    expected_out[$];
  coef_item_t cur_item;

  mode_t  mdl_mode;
  logic   mdl_zero_mean;
  longint mdl_mean_gain;

  int in_idle_pct;
  int out_idle_pct;
  int errors;
  int n_results;
  int n_blocks;
  longint cycles = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  spectral_coef_shrink u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_real(in_coef_real), .in_coef_imag(in_coef_imag),
    .in_noise_level(in_noise_level), .in_ref_real(in_ref_real),
    .in_ref_imag(in_ref_imag), .in_block_first(in_block_first),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_real(out_real), .out_imag(out_imag)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned umag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unsigned mul_round_sat(longint unsigned a, longint unsigned b,
                                                    longint unsigned lim);
    longint unsigned p;
    if (a != 0 && b > P62 / a) return lim;
    p = a * b;
    p = (p + (64'd1 << (FRAC - 1))) >> FRAC;
    return p > lim ? lim : p;
  endfunction

  function automatic longint unsigned wiener_frac(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = num >= den ? 1 : 0;
    r = q != 0 ? num - den : num;
    for (int i = 0; i < FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint signed_mag(longint unsigned m, logic neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint ref_scaled(longint r);
    longint unsigned m;
    m = mul_round_sat(umag(mdl_mean_gain), umag(r), D_LIM);
    return signed_mag(m, (mdl_mean_gain < 0) != (r < 0));
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_coef(longint v);
    longint hi;
    hi = (longint'(1) << (COEF_W - 1)) - 1;
    return COEF_W'(clip(v, -hi - 1, hi));
  endfunction

  task automatic predict_shrink(coef_item_t it);
    longint cr, ci, rr, ri, mr, mi, dr, di;
    longint unsigned sigma, psd, gain, q, sr, si;
    shrunk_t res;
    cr = it.coef_real;
    ci = it.coef_imag;
    rr = it.ref_real;
    ri = it.ref_imag;
    sigma = it.noise_level;
    mr = 0;
    mi = 0;
    dr = cr;
    di = ci;
    if (it.block_first) begin
      if (rr == 0) begin
        mdl_mean_gain = 0;
      end else begin
        q = (umag(cr) << FRAC) / umag(rr);
        if ((cr < 0) != (rr < 0))
          mdl_mean_gain = q > (64'd1 << 39) ? MG_MIN : -longint'(q);
        else
          mdl_mean_gain = q > longint'(MG_MAX) ? MG_MAX : longint'(q);
      end
    end
    if (mdl_zero_mean) begin
      mr = ref_scaled(rr);
      mi = ref_scaled(ri);
      dr = clip(cr - mr, -longint'(D_LIM), longint'(D_LIM));
      di = clip(ci - mi, -longint'(D_LIM), longint'(D_LIM));
    end
    psd = umag(dr) * umag(dr) + umag(di) * umag(di);
    case (mdl_mode)
      MODE_WIENER, MODE_SQRT: begin
        if (psd == 0 || psd <= sigma) gain = 0;
        else gain = wiener_frac(psd - sigma, psd);
        if (mdl_mode == MODE_SQRT) gain = int_sqrt(gain << FRAC);
      end
      MODE_HARD: gain = psd < sigma ? 0 : (64'd1 << FRAC);
      default: gain = sigma;
    endcase
    sr = mul_round_sat(umag(dr), gain, SCL_LIM);
    si = mul_round_sat(umag(di), gain, SCL_LIM);
    res.re = sat_coef(signed_mag(sr, dr < 0) + mr);
    res.im = sat_coef(signed_mag(si, di < 0) + mi);
    expected_out.insert(expected_out.size(), res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_shrink(cur_item);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_coef_real   <= cur_item.coef_real;
          in_coef_imag   <= cur_item.coef_imag;
          in_noise_level <= cur_item.noise_level;
          in_ref_real    <= cur_item.ref_real;
          in_ref_imag    <= cur_item.ref_imag;
          in_block_first <= cur_item.block_first;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    shrunk_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected: real %0d imag %0d",
                   $realtime, out_real, out_imag);
        end else begin
          exp_res = expected_out.pop_front();
          if (out_real !== exp_res.re) begin
            errors++;
            $display("%0t: out_real expected %0d actual %0d", $realtime, exp_res.re, out_real);
          end
          if (out_imag !== exp_res.im) begin
            errors++;
            $display("%0t: out_imag expected %0d actual %0d", $realtime, exp_res.im, out_imag);
          end
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= 2000;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("Timed out after %0d cycles with %0d items outstanding.",
               cycles, expected_out.size() + pending_items.size());
      $display("FAIL spectral_coef_shrink");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_FILTER_MODE) mdl_mode = mode_t'(val);
    else mdl_zero_mean = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (pending_items.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_item(coef_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] r;
    int w;
    case ($urandom_range(9))
      0: r = {1'b0, {(COEF_W-1){1'b1}}};
      1: r = {1'b1, {(COEF_W-1){1'b0}}};
      2: r = '0;
      default: begin
        w = $urandom_range(1, COEF_W);
        r = COEF_W'($urandom);
        r = r >>> (COEF_W - w);
      end
    endcase
    return r;
  endfunction

  function automatic logic [NOISE_W-1:0] rand_noise(logic signed [COEF_W-1:0] cr,
                                                    logic signed [COEF_W-1:0] ci);
    longint unsigned p;
    logic [NOISE_W-1:0] full;
    p = umag(cr) * umag(cr) + umag(ci) * umag(ci);
    full = NOISE_W'({$urandom, $urandom});
    case ($urandom_range(5))
      0: return '0;
      1: return full;
      2: return full >> $urandom_range(0, NOISE_W - 1);
      3: return NOISE_W'(p + $urandom_range(0, 2) - 1);
      4: return NOISE_W'($urandom_range(0, 1 << (FRAC + 1)));
      default: return NOISE_W'(p >> $urandom_range(0, 8));
    endcase
  endfunction

  function automatic coef_item_t rand_item(logic first);
    coef_item_t it;
    it.coef_real = rand_coef();
    it.coef_imag = rand_coef();
    it.ref_real = rand_coef();
    it.ref_imag = rand_coef();
    it.noise_level = rand_noise(it.coef_real, it.coef_imag);
    it.block_first = first;
    return it;
  endfunction

  function automatic coef_item_t mk_item(longint cr, longint ci, longint unsigned nl,
                                         longint rr, longint ri, logic first);
    coef_item_t it;
    it.coef_real = COEF_W'(cr);
    it.coef_imag = COEF_W'(ci);
    it.noise_level = NOISE_W'(nl);
    it.ref_real = COEF_W'(rr);
    it.ref_imag = COEF_W'(ri);
    it.block_first = first;
    return it;
  endfunction

  task automatic queue_random(int count);
    int left;
    int blen;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        add_item(rand_item(1'($urandom_range(1))));
        left--;
      end else begin
        blen = $urandom_range(1, 8);
        n_blocks++;
        for (int k = 0; k < blen && left > 0; k++) begin
          add_item(rand_item(k == 0));
          left--;
        end
      end
    end
  endtask

  initial begin
    longint mx, mn;
    errors = 0;
    n_results = 0;
    n_blocks = 0;
    in_idle_pct = 12;
    out_idle_pct = 80;
    mdl_mode = MODE_WIENER;
    mdl_zero_mean = 1'b1;
    mdl_mean_gain = 0;
    mx = 8388607;
    mn = -8388608;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Before any block start the mean gain is still zero.
    add_item(mk_item(1000, -2000, 5000, 300, 400, 1'b0));
    add_item(mk_item(mx, mn, 0, mx, mn, 1'b0));
    // A zero reference DC clears the mean gain.
    add_item(mk_item(5000, 0, 100, 0, 7, 1'b1));
    add_item(mk_item(mn, mx, 1, 1, -1, 1'b1));
    add_item(mk_item(mx, mx, 64'hFFFF_FFFF_FFFF, -1, 1, 1'b1));
    add_item(mk_item(12345, -5432, 1000, 100, -50, 1'b1));
    add_item(mk_item(1234, 5678, 0, 100, -50, 1'b0));
    add_item(mk_item(0, 0, 0, 0, 0, 1'b1));
    add_item(mk_item(0, 0, 0, 0, 0, 1'b0));
    add_item(mk_item(3, 4, 25, 0, 0, 1'b0));
    add_item(mk_item(3, 4, 24, 0, 0, 1'b0));
    add_item(mk_item(3, 4, 26, 0, 0, 1'b0));
    add_item(mk_item(mn, mn, 1, mn, mn, 1'b1));
    add_item(mk_item(-7, 9, 64'hFFFF_FFFF_FFFF, 2, 3, 1'b0));
    drain();

    write_reg(REG_ZERO_MEAN, 2'd0);
    write_reg(REG_FILTER_MODE, MODE_MULT);
    add_item(mk_item(mx, mn, 64'hFFFF_FFFF_FFFF, 1, 1, 1'b1));
    add_item(mk_item(100, -100, 64'd1 << FRAC, 1, 1, 1'b0));
    add_item(mk_item(-3, 3, 64'd1 << (FRAC - 1), 1, 1, 1'b0));
    add_item(mk_item(mx, mx, 0, 1, 1, 1'b0));
    drain();
    write_reg(REG_FILTER_MODE, MODE_HARD);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        in_idle_pct = 12;
        out_idle_pct = 80;
      end else if (ph < 8) begin
        in_idle_pct = 80;
        out_idle_pct = 12;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      write_reg(REG_FILTER_MODE, 2'(ph % 4));
      write_reg(REG_ZERO_MEAN, 2'(((ph >> 2) ^ ph) & 1));
      queue_random(150);
      if (ph == 8) begin
        repeat (20) @(posedge clk);
        hold_go <= 1'b1;
      end
      drain();
    end

    if (expected_out.size() != 0) errors++;
    $display("Checked %0d result items across all four modes, zero-mean on and off,",
             n_results);
    $display("%0d random blocks, both idling patterns and one long receiver stall.",
             n_blocks);
    if (errors == 0) begin
      $display("PASS spectral_coef_shrink");
    end else begin
      $display("FAIL spectral_coef_shrink");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
sv/scs_pkg.sv
sv/spectral_coef_shrink.sv
verif/testbench.sv
